@@ rtl/tabu_move_list_engine_assert.svh @@
// Assertion macros for the tabu move list engine.
`ifndef TABU_MOVE_LIST_ENGINE_ASSERT_SVH
`define TABU_MOVE_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define TML_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tabu move list engine: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define TML_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tabu move list engine: next-cycle check failed");
`else
`define TML_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TML_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/tml_pkg.sv @@
// Shared types and constants of the tabu move list engine.
package tml_pkg;

    localparam int TEN_W      = 8;
    localparam int CAP_W      = 5;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TENURE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

    localparam logic [TEN_W-1:0] TENURE_RST   = 8'd7;
    localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // capture the item, clear the lookup
        logic scan;     // walk the table comparing pairs
        logic restart;  // rewind the read pointer for the compaction walk
        logic compact;  // walk the table, age and compact
        logic finish;   // append, commit count, load the result
    } tml_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic look_done;
        logic comp_done;
    } tml_sts_t;

endpackage

@@ rtl/tml_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tml_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tml_ctrl.sv @@
// Controller state machine: sequences lookup, compaction and result hand-off.
module tml_ctrl import tml_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  tml_sts_t sts,
    output tml_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_COMP = 4'b0100,
        ST_FIN  = 4'b1000
    } tml_state_t;

    tml_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (sts.look_done) begin
                    cmd.restart = 1'b1;
                    state_next  = ST_COMP;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_COMP: begin
                if (sts.comp_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.compact = 1'b1;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.finish || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/tml_dp.sv @@
// Datapath: configuration, entry table, lookup compare, aging and compaction.
module tml_dp import tml_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int NODE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tml_cmd_t              cmd,
    output tml_sts_t              sts,
    input  logic [NODE_BITS-1:0]  in_first,
    input  logic [NODE_BITS-1:0]  in_second,
    input  logic                  in_better,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  res_accepted,
    output logic                  res_forbidden,
    output logic [HELD_W-1:0]     res_held
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ENT_W = 2 * NODE_BITS + TEN_W;

    // configuration and control state
    logic [TEN_W-1:0] tenure_reg, tenure_next;
    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_vld_reg, rd_vld_next;

    // walk state and item payload
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     dst_reg, dst_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [NODE_BITS-1:0] first_reg, first_next;
    logic [NODE_BITS-1:0] second_reg, second_next;
    logic                 better_reg, better_next;
    logic                 acc_reg, acc_next;
    logic                 forb_reg, forb_next;
    logic [HELD_W-1:0]    held_reg, held_next;

    logic                 rd_more, rd_issue, hit, keep, drop_en, append_en;
    logic [IDX_W-1:0]     drop_idx;
    logic [CMP_W-1:0]     cap_ext, ecap, count_ext;
    logic [CNT_W-1:0]     new_cnt;
    logic [ENT_W-1:0]     rdata, wdata;
    logic [NODE_BITS-1:0] ent_first, ent_second;
    logic [TEN_W-1:0]     ent_ctr;
    logic                 we;

    assign rd_more  = rd_ptr_reg < count_reg;
    assign rd_issue = (cmd.scan || cmd.compact) && rd_more;

    assign ent_first  = rdata[ENT_W-1 -: NODE_BITS];
    assign ent_second = rdata[TEN_W +: NODE_BITS];
    assign ent_ctr    = rdata[TEN_W-1:0];

    assign hit = rd_vld_reg && (ent_first == first_reg) && (ent_second == second_reg);

    // usable capacity: zero counts as one, clip at the built depth
    always_comb begin
        cap_ext = CMP_W'(capacity_reg);
        ecap    = cap_ext;
        if (cap_ext == '0) begin
            ecap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            ecap = CMP_W'(DEPTH);
        end
    end

    assign count_ext = CMP_W'(count_reg);

    // a hit drops its own entry when the move beats the best; a miss on a
    // full table drops the oldest entry
    assign drop_en  = found_reg ? better_reg : ((count_ext >= ecap) && (count_reg != '0));
    assign drop_idx = found_reg ? pos_reg : '0;
    assign keep     = !(drop_en && (rd_idx_reg == drop_idx)) && (ent_ctr > TEN_W'(1));

    assign append_en = !found_reg && (tenure_reg > TEN_W'(1));
    assign new_cnt   = dst_reg + CNT_W'(append_en);

    always_comb begin
        we    = 1'b0;
        wdata = {ent_first, ent_second, ent_ctr - TEN_W'(1)};
        if (cmd.compact && rd_vld_reg && keep) begin
            we = 1'b1;
        end else if (cmd.finish && append_en) begin
            we    = 1'b1;
            wdata = {first_reg, second_reg, tenure_reg - TEN_W'(1)};
        end
    end

    tml_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (dst_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (rd_issue),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        tenure_next   = tenure_reg;
        capacity_next = capacity_reg;
        count_next    = count_reg;
        rd_vld_next   = rd_issue;
        rd_ptr_next   = rd_ptr_reg;
        rd_idx_next   = rd_idx_reg;
        dst_next      = dst_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        better_next   = better_reg;
        acc_next      = acc_reg;
        forb_next     = forb_reg;
        held_next     = held_reg;

        priority if (cfg_we && (cfg_index == CFG_TENURE)) begin
            tenure_next = cfg_data[TEN_W-1:0];
        end else if (cfg_we && (cfg_index == CFG_CAPACITY)) begin
            capacity_next = cfg_data[CAP_W-1:0];
        end

        if (rd_issue) begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            rd_idx_next = rd_ptr_reg[IDX_W-1:0];
        end

        if (cmd.start) begin
            first_next  = in_first;
            second_next = in_second;
            better_next = in_better;
            found_next  = 1'b0;
            rd_ptr_next = '0;
        end

        // keep only the oldest match
        if (cmd.scan && hit && !found_reg) begin
            found_next = 1'b1;
            pos_next   = rd_idx_reg;
        end

        if (cmd.restart) begin
            rd_ptr_next = '0;
            dst_next    = '0;
        end

        if (cmd.compact && rd_vld_reg && keep) begin
            dst_next = dst_reg + CNT_W'(1);
        end

        if (cmd.finish) begin
            count_next = new_cnt;
            acc_next   = !found_reg || better_reg;
            forb_next  = found_reg;
            held_next  = HELD_W'(new_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tenure_reg   <= TENURE_RST;
            capacity_reg <= CAPACITY_RST;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            tenure_reg   <= tenure_next;
            capacity_reg <= capacity_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        rd_idx_reg <= rd_idx_next;
        dst_reg    <= dst_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        better_reg <= better_next;
        acc_reg    <= acc_next;
        forb_reg   <= forb_next;
        held_reg   <= held_next;
    end

    assign sts.look_done = found_reg || (!rd_more && !rd_vld_reg);
    assign sts.comp_done = !rd_more && !rd_vld_reg;

    assign res_accepted  = acc_reg;
    assign res_forbidden = forb_reg;
    assign res_held      = held_reg;

endmodule

@@ rtl/tabu_move_list_engine.sv @@
// Top level of the tabu move list engine.
//
// Keeps an age-ordered table of forbidden swap moves, each a node pair with a
// tenure countdown, and judges one candidate move per item. A pair not in the
// table is accepted and appended with the configured tenure, evicting the
// oldest entry if the table holds capacity entries or more. A pair in the table
// is accepted only when beats_best is set, and then its own entry is dropped;
// otherwise it is rejected. Afterwards every counter is decremented and entries
// at zero are removed, survivors kept in age order. Each item yields exactly one
// result: accepted, was_forbidden and entries_held (count after aging, low five
// bits). The table lives in one RAM with one read and one write port, so each
// item walks it twice: a lookup pass that stops at the first hit, then an
// age-and-compact pass; the last step also holds while an earlier result still
// waits. One item is worked on at a time, and the next item is taken while a
// result waits in the output register. The table needs no clearing after reset:
// only the entries below the held count are ever read. Configuration writes are
// always taken (cfg_ready is tied high) and must only be issued while the block
// is idle. Register 0 is tenure (reset 7), register 1 is capacity (reset 16);
// other indexes are ignored. A capacity of zero acts as one, and one above
// DEPTH as DEPTH.
`include "tabu_move_list_engine_assert.svh"

module tabu_move_list_engine import tml_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int NODE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // candidate move
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [NODE_BITS-1:0]  s_node_first,
    input  logic [NODE_BITS-1:0]  s_node_second,
    input  logic                  s_beats_best,

    // verdict
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic                  m_was_forbidden,
    output logic [HELD_W-1:0]     m_entries_held,

    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tml_cmd_t cmd;
    tml_sts_t sts;

    // registers are always writable; the user keeps writes to idle periods
    assign cfg_ready = 1'b1;

    // sequence the lookup walk, the compaction walk and the result hand-off
    tml_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hold the table, the registers and the result payload
    tml_dp #(
        .DEPTH     (DEPTH),
        .NODE_BITS (NODE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_first      (s_node_first),
        .in_second     (s_node_second),
        .in_better     (s_beats_best),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .res_accepted  (m_accepted),
        .res_forbidden (m_was_forbidden),
        .res_held      (m_entries_held)
    );

    // one item in flight: the input closes right after an item is taken
    `TML_ASSERT_NXT(a_single_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a move absent from the table is always taken
    `TML_ASSERT_IMP(a_free_move_taken, aclk, aresetn, m_valid && !m_was_forbidden, m_accepted)
    // the held count never exceeds the built depth
    `TML_ASSERT_IMP(a_held_in_depth, aclk, aresetn, m_valid, int'(m_entries_held) <= DEPTH)

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the tabu move list engine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tml_pkg::*;

    localparam int DEPTH        = 16;
    localparam int NODE_BITS    = 8;
    localparam int MAX_GAP      = 18;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 86;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_AT      = 500;   // result count at which the receiver holds off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;    // longer than the worst item latency
    localparam int REPORT_MAX   = 10;

    // Register indexes the block decodes as nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // One verdict, in port order.
    typedef struct packed {
        logic              accepted;
        logic              was_forbidden;
        logic [HELD_W-1:0] entries_held;
    } verdict_t;

    // One forbidden move with its remaining tenure.
    typedef struct packed {
        logic [NODE_BITS-1:0] first;
        logic [NODE_BITS-1:0] second;
        logic [TEN_W-1:0]     countdown;
    } move_slot_t;

    // One row of the directed plan: either a register write or a move.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [NODE_BITS-1:0]  first;
        logic [NODE_BITS-1:0]  second;
        logic                  beats;
        logic                  typed;
        verdict_t              verdict;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [NODE_BITS-1:0]  s_node_first;
    logic [NODE_BITS-1:0]  s_node_second;
    logic                  s_beats_best;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_accepted;
    logic                  m_was_forbidden;
    logic [HELD_W-1:0]     m_entries_held;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the move table and the registers.
    move_slot_t       tabu_table [DEPTH];
    int               tabu_count;
    logic [TEN_W-1:0] cur_tenure;
    logic [CAP_W-1:0] cur_capacity;

    verdict_t  verdicts_due [$];
    plan_row_t directed_plan [$];
    int        mismatch_count;
    int        sent_total;
    bit        tx_quiet;

    logic [CFG_DATA_W-1:0] phase_tenure   [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_capacity [NUM_PHASES];

    tabu_move_list_engine #(
        .DEPTH     (DEPTH),
        .NODE_BITS (NODE_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_node_first    (s_node_first),
        .s_node_second   (s_node_second),
        .s_beats_best    (s_beats_best),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_was_forbidden (m_was_forbidden),
        .m_entries_held  (m_entries_held),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Remove one slot and close the gap, keeping age order.
    function automatic void drop_slot(int pos);
        int k;
        for (k = pos; k + 1 < tabu_count; k++)
            tabu_table[k] = tabu_table[k + 1];
        tabu_count--;
    endfunction

    // Judge one candidate move against the shadow table and update it.
    function automatic verdict_t predict_verdict(logic [NODE_BITS-1:0] a,
                                                 logic [NODE_BITS-1:0] b,
                                                 logic better);
        int       hit_pos;
        int       limit;
        int       kept;
        int       k;
        verdict_t v;
        hit_pos = -1;
        for (k = 0; k < tabu_count; k++)
            if (hit_pos < 0 && tabu_table[k].first == a && tabu_table[k].second == b)
                hit_pos = k;
        if (hit_pos < 0) begin
            // Zero capacity acts as one, anything above the depth as the depth.
            limit = (cur_capacity == 0) ? 1 : (cur_capacity > DEPTH) ? DEPTH : cur_capacity;
            if (tabu_count >= limit && tabu_count > 0)
                drop_slot(0);
            if (tabu_count < DEPTH) begin
                tabu_table[tabu_count].first     = a;
                tabu_table[tabu_count].second    = b;
                tabu_table[tabu_count].countdown = cur_tenure;
                tabu_count++;
            end
        end else if (better) begin
            drop_slot(hit_pos);
        end
        // Age: a countdown at 0 or 1 expires, the rest tick down and compact.
        kept = 0;
        for (k = 0; k < tabu_count; k++) begin
            if (tabu_table[k].countdown > 1) begin
                tabu_table[kept] = tabu_table[k];
                tabu_table[kept].countdown = tabu_table[k].countdown - 1'b1;
                kept++;
            end
        end
        tabu_count = kept;
        v.accepted      = (hit_pos < 0) || better;
        v.was_forbidden = (hit_pos >= 0);
        v.entries_held  = tabu_count[HELD_W-1:0];
        return v;
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic plan_row_t move_row(logic [NODE_BITS-1:0] a, logic [NODE_BITS-1:0] b,
                                           logic bb);
        plan_row_t r;
        r = '0;
        r.first  = a;
        r.second = b;
        r.beats  = bb;
        return r;
    endfunction

    function automatic plan_row_t checked_row(logic [NODE_BITS-1:0] a,
                                              logic [NODE_BITS-1:0] b, logic bb,
                                              logic acc, logic fw, logic [HELD_W-1:0] held);
        plan_row_t r;
        r = move_row(a, b, bb);
        r.typed   = 1'b1;
        r.verdict = {acc, fw, held};
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic note_mismatch(verdict_t want, verdict_t seen, bit orphan);
        if (mismatch_count < REPORT_MAX) begin
            if (orphan)
                $display("mismatch: result acc=%0d fw=%0d held=%0d with no item pending",
                         seen.accepted, seen.was_forbidden, seen.entries_held);
            else
                $display("mismatch: expected acc=%0d fw=%0d held=%0d, got acc=%0d fw=%0d held=%0d",
                         want.accepted, want.was_forbidden, want.entries_held,
                         seen.accepted, seen.was_forbidden, seen.entries_held);
        end
        mismatch_count++;
    endtask

    // Offer one move after a random gap; predict its verdict on acceptance.
    task automatic send_move(logic [NODE_BITS-1:0] a, logic [NODE_BITS-1:0] b, logic bb,
                             bit typed, verdict_t typed_verdict);
        int       gap;
        verdict_t v;
        if (sent_total % 64 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = draw_gap(tx_quiet);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_node_first  = a;
        s_node_second = b;
        s_beats_best  = bb;
        do @(posedge aclk); while (!s_ready);
        v = predict_verdict(a, b, bb);
        verdicts_due.push_back(typed ? typed_verdict : v);
        sent_total++;
    endtask

    // Drop valid and hold until every verdict is back, leaving the block idle.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_TENURE)
            cur_tenure = val[TEN_W-1:0];
        else if (idx == CFG_CAPACITY)
            cur_capacity = val[CAP_W-1:0];
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random ready gaps, one long hold-off, check every verdict.
    initial begin : verdict_side
        int       gap;
        int       got;
        bit       rx_quiet;
        verdict_t seen;
        verdict_t want;
        m_ready  = 1'b0;
        got      = 0;
        rx_quiet = 1'b0;
        @(posedge aresetn);
        forever begin
            if (got % 64 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            // Hold off long once so the block fills up and stalls its input.
            gap = (got == HOLD_AT) ? HOLD_CYCLES : draw_gap(rx_quiet);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            seen = {m_accepted, m_was_forbidden, m_entries_held};
            if (verdicts_due.size() == 0) begin
                note_mismatch(seen, seen, 1'b1);
            end else begin
                want = verdicts_due.pop_front();
                if (seen.accepted !== want.accepted ||
                    seen.was_forbidden !== want.was_forbidden ||
                    seen.entries_held !== want.entries_held)
                    note_mismatch(want, seen, 1'b0);
            end
            got++;
        end
    end

    // Stimulus: reset, directed plan, then random phases under varied settings.
    initial begin : move_side
        int                   p;
        int                   n;
        int                   pick;
        logic [NODE_BITS-1:0] a;
        logic [NODE_BITS-1:0] b;
        logic [15:0]          pair;
        logic [15:0]          recent_pairs [$];
        plan_row_t            row;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_node_first  = '0;
        s_node_second = '0;
        s_beats_best  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatch_count = 0;
        sent_total     = 0;
        tx_quiet       = 1'b0;
        tabu_count     = 0;
        cur_tenure     = TENURE_RST;
        cur_capacity   = CAPACITY_RST;

        // Settings per random phase; raise tenure to 255 at full capacity and
        // then lower capacity to 4, so the table holds more than capacity.
        phase_tenure   = '{8'd7, 8'd1, 8'd255, 8'd3, 8'd0, 8'd2,
                           8'd16, 8'd255, 8'd5, 8'd30, 8'd200, 8'd128};
        phase_capacity = '{8'd16, 8'd1, 8'd16, 8'h04, 8'd5, 8'd0,
                           8'hFF, 8'h11, 8'd2, 8'hE8, 8'd16, 8'd3};

        // Directed plan, reset settings first (tenure 7, capacity 16).
        directed_plan.push_back(checked_row(8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 5'd1));
        directed_plan.push_back(checked_row(8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 5'd1));
        directed_plan.push_back(checked_row(8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 5'd0));
        directed_plan.push_back(checked_row(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 5'd1));
        directed_plan.push_back(checked_row(8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, 5'd2));
        directed_plan.push_back(checked_row(8'h00, 8'hFF, 1'b0, 1'b1, 1'b0, 5'd3));
        directed_plan.push_back(checked_row(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1, 5'd3));
        directed_plan.push_back(checked_row(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 5'd2));
        directed_plan.push_back(checked_row(8'hAA, 8'h55, 1'b0, 1'b1, 1'b0, 5'd3));
        // Oldest entry expires in the same step as this insert.
        directed_plan.push_back(checked_row(8'h55, 8'hAA, 1'b1, 1'b1, 1'b0, 5'd3));
        directed_plan.push_back(checked_row(8'h55, 8'hAA, 1'b0, 1'b0, 1'b1, 5'd2));
        directed_plan.push_back(checked_row(8'hAA, 8'h55, 1'b1, 1'b1, 1'b1, 5'd1));
        // Capacity two with long tenure: the second insert evicts the oldest.
        directed_plan.push_back(reg_row(CFG_TENURE, 8'd255));
        directed_plan.push_back(reg_row(CFG_CAPACITY, 8'd2));
        directed_plan.push_back(checked_row(8'h01, 8'h02, 1'b0, 1'b1, 1'b0, 5'd2));
        directed_plan.push_back(checked_row(8'h03, 8'h04, 1'b0, 1'b1, 1'b0, 5'd2));
        // Zero capacity acts as one; the table already holds two, evict one only.
        directed_plan.push_back(reg_row(CFG_CAPACITY, 8'd0));
        directed_plan.push_back(checked_row(8'h05, 8'h06, 1'b0, 1'b1, 1'b0, 5'd2));
        directed_plan.push_back(checked_row(8'h03, 8'h04, 1'b0, 1'b0, 1'b1, 5'd2));
        // Zero tenure: the new move leaves the table in its own step.
        directed_plan.push_back(reg_row(CFG_TENURE, 8'd0));
        directed_plan.push_back(checked_row(8'h07, 8'h08, 1'b0, 1'b1, 1'b0, 5'd1));
        // Capacity above the depth saturates; unknown indexes change nothing.
        directed_plan.push_back(reg_row(CFG_CAPACITY, 8'd31));
        directed_plan.push_back(reg_row(CFG_SPARE_A, 8'hFF));
        directed_plan.push_back(reg_row(CFG_SPARE_B, 8'h00));
        directed_plan.push_back(reg_row(CFG_TENURE, 8'd1));
        directed_plan.push_back(checked_row(8'h09, 8'h0A, 1'b1, 1'b1, 1'b0, 5'd1));
        directed_plan.push_back(reg_row(CFG_CAPACITY, 8'hF0));
        directed_plan.push_back(reg_row(CFG_TENURE, 8'd9));
        directed_plan.push_back(move_row(8'h0F, 8'hF0, 1'b1));
        directed_plan.push_back(move_row(8'hF0, 8'h0F, 1'b0));
        directed_plan.push_back(move_row(8'h0F, 8'hF0, 1'b0));
        directed_plan.push_back(move_row(8'h05, 8'h06, 1'b0));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Walk the directed plan; write registers only once the block is idle.
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_reg) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_move(row.first, row.second, row.beats, row.typed, row.verdict);
            end
        end

        // Random phases: about half replay recent pairs so the table gets hits,
        // plus small node values that collide and full-range values for bits.
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_TENURE, phase_tenure[p]);
            write_reg(CFG_CAPACITY, phase_capacity[p]);
            write_reg((p % 2) ? CFG_SPARE_B : CFG_SPARE_A,
                      CFG_DATA_W'($urandom_range(0, 255)));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick <= 4 && recent_pairs.size() != 0) begin
                    pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                    // Swap the halves now and then: order within a pair matters.
                    if (pick == 4)
                        pair = {pair[7:0], pair[15:8]};
                end else if (pick <= 6) begin
                    pair = {8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))};
                end else begin
                    pair = 16'($urandom_range(0, 65535));
                end
                a = pair[15:8];
                b = pair[7:0];
                send_move(a, b, ($urandom_range(0, 2) == 0), 1'b0, '0);
                recent_pairs.push_back(pair);
                if (recent_pairs.size() > POOL_SIZE)
                    void'(recent_pairs.pop_front());
            end
        end

        // Drain, then give a stray result time to show up.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tml_pkg.sv
rtl/tml_ram.sv
rtl/tml_ctrl.sv
rtl/tml_dp.sv
rtl/tabu_move_list_engine.sv
bench/testbench.sv
